>>> hw/rtl/bpeg_pkg.sv
// Shared types and constants for the binary polynomial extended GCD block.
// No dependencies; imported by bpeg_seq and binary_poly_extended_gcd.
package bpeg_pkg;

  localparam int unsigned POLY_BITS_DEF = 33;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_DEC1,
    ACT_DEC0,
    ACT_REDUCE,
    ACT_SWAP,
    ACT_FINISH
  } action_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic req_valid;
    logic out_free;
    logic r1_zero;
    logic r1_lead;
    logic r0_lead;
    logic d0_zero;
    logic d0_ge_d1;
  } status_t;

endpackage

>>> hw/rtl/binary_poly_extended_gcd.sv
// Top level of the binary polynomial extended GCD (GF(2)[x] extended Euclid).
// Depends on bpeg_pkg, bpeg_shxor and bpeg_seq.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  req     | req_valid, req_ready, poly_a, poly_b | in
//  rsp     | rsp_valid, rsp_ready, gcd_poly,      | out
//          | coef_a, coef_b                       |
//
// One item at a time. After the req transfer the sequencer issues one action per
// cycle on the shared shift-xor unit: degree decrement of either remainder, a
// reduction r0 ^= r1 << (d0-d1) with the same shift applied to the Bezout pairs,
// or a swap at the end of each division round.
// Reset clears the sequencer and rsp_valid only. A finished result waits in the
// output register, so req is taken again while rsp is stalled; the next result
// holds in DONE until the output register is freed.
module binary_poly_extended_gcd #(
  parameter int unsigned POLY_BITS = bpeg_pkg::POLY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic [POLY_BITS-1:0] poly_a,
  input  logic [POLY_BITS-1:0] poly_b,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output logic [POLY_BITS-1:0] gcd_poly,
  output logic [POLY_BITS-1:0] coef_a,
  output logic [POLY_BITS-1:0] coef_b
);
  import bpeg_pkg::*;

  localparam int unsigned DW = (POLY_BITS > 1) ? $clog2(POLY_BITS) : 1;

  // working remainders, Bezout pairs and degree bounds
  logic [POLY_BITS-1:0] r0, r1, s0, s1, t0, t1;
  logic [DW-1:0]        d0, d1;

  logic [POLY_BITS-1:0] red_r, red_s, red_t;
  logic [DW-1:0]        shamt;
  status_t              status;
  action_t              action;
  logic                 out_free;

  assign out_free = !rsp_valid || rsp_ready;
  assign shamt    = d0 - d1;

  always_comb begin
    status.req_valid = req_valid;
    status.out_free  = out_free;
    status.r1_zero   = (r1 == '0);
    status.r1_lead   = r1[d1];
    status.r0_lead   = r0[d0];
    status.d0_zero   = (d0 == '0);
    status.d0_ge_d1  = (d0 >= d1);
  end

  bpeg_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .action    (action),
    .req_ready (req_ready)
  );

  // quotient term x^shamt folded straight into the remainder and both pairs
  bpeg_shxor #(
    .WIDTH (POLY_BITS),
    .SW    (DW)
  ) u_shxor (
    .x_r (r0),
    .x_s (s0),
    .x_t (t0),
    .y_r (r1),
    .y_s (s1),
    .y_t (t1),
    .sh  (shamt),
    .z_r (red_r),
    .z_s (red_s),
    .z_t (red_t)
  );

  always_ff @(posedge clk) begin
    unique case (action)
      ACT_LOAD: begin
        r0 <= poly_a;
        r1 <= poly_b;
        s0 <= POLY_BITS'(1);
        s1 <= '0;
        t0 <= '0;
        t1 <= POLY_BITS'(1);
        d0 <= DW'(POLY_BITS - 1);
        d1 <= DW'(POLY_BITS - 1);
      end
      ACT_DEC1: begin
        d1 <= d1 - DW'(1);
      end
      ACT_DEC0: begin
        d0 <= d0 - DW'(1);
      end
      ACT_REDUCE: begin
        // leading bit of r0 is cleared, so drop its degree bound as well
        r0 <= red_r;
        s0 <= red_s;
        t0 <= red_t;
        if (d0 != '0) d0 <= d0 - DW'(1);
      end
      ACT_SWAP: begin
        // end of a division round: remainder moves down, pairs advance
        r0 <= r1;
        r1 <= r0;
        s0 <= s1;
        s1 <= s0;
        t0 <= t1;
        t1 <= t0;
        d0 <= d1;
        d1 <= d0;
      end
      ACT_NONE, ACT_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // output register: hold the result until the rsp transfer
  always_ff @(posedge clk) begin
    if (action == ACT_FINISH) begin
      gcd_poly <= r0;
      coef_a   <= s0;
      coef_b   <= t0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (action == ACT_FINISH) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/bpeg_shxor.sv
// Shared shift-and-xor unit: z = x ^ (y << sh) on three lanes (r, s, t).
// No dependencies.
module bpeg_shxor #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned SW    = 6
) (
  input  logic [WIDTH-1:0] x_r,
  input  logic [WIDTH-1:0] x_s,
  input  logic [WIDTH-1:0] x_t,
  input  logic [WIDTH-1:0] y_r,
  input  logic [WIDTH-1:0] y_s,
  input  logic [WIDTH-1:0] y_t,
  input  logic [SW-1:0]    sh,
  output logic [WIDTH-1:0] z_r,
  output logic [WIDTH-1:0] z_s,
  output logic [WIDTH-1:0] z_t
);

  assign z_r = x_r ^ (y_r << sh);
  assign z_s = x_s ^ (y_s << sh);
  assign z_t = x_t ^ (y_t << sh);

endmodule

>>> hw/rtl/bpeg_seq.sv
// Sequencer for the extended GCD: picks one datapath action per cycle.
// Depends on bpeg_pkg (state_t, action_t, status_t).
module bpeg_seq (
  input  logic              clk,
  input  logic              rst,
  input  bpeg_pkg::status_t status,
  output bpeg_pkg::action_t action,
  output logic              req_ready
);
  import bpeg_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (status.req_valid) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (status.r1_zero) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    action    = ACT_NONE;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // hold off the req transfer while reset is applied
        req_ready = !rst;
        if (status.req_valid && !rst) action = ACT_LOAD;
      end
      ST_RUN: begin
        // normalize degrees first, then reduce or end the round
        priority if (status.r1_zero) action = ACT_NONE;
        else if (!status.r1_lead) action = ACT_DEC1;
        else if (!status.r0_lead && !status.d0_zero) action = ACT_DEC0;
        else if (status.r0_lead && status.d0_ge_d1) action = ACT_REDUCE;
        else action = ACT_SWAP;
      end
      ST_DONE: begin
        if (status.out_free) action = ACT_FINISH;
      end
      default: action = ACT_NONE;
    endcase
  end

endmodule
